// ----- hdl/xkfc_pkg.sv -----
// Shared types and constants of the keyed frame checker.
`timescale 1ns / 1ps
`default_nettype none

package xkfc_pkg;

   // One received byte with its first-byte side information.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       first_byte;
      logic [5:0] fifo_count;
      logic       crc_error;
   } req_type;

   // One frame verdict with the decrypted payload fields.
   typedef struct packed {
      logic [2:0]  status;
      logic        accepted;
      logic [7:0]  pkt_type;
      logic [7:0]  command;
      logic [15:0] pair_key_out;
      logic [7:0]  key_value;
      logic [7:0]  reserved_byte;
      logic [15:0] received_id;
   } rsp_type;

   // Configuration as seen by the frame logic.
   typedef struct packed {
      logic [15:0] device_id;
      logic        pairing_enable;
   } cfg_type;

   // Configuration port layout.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ID      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAIRING_ENABLE = 2'd1;
   localparam logic [15:0] DEVICE_ID_RESET = 16'h1111;

   // Frame verdict codes.
   localparam logic [2:0] ST_COUNT_RANGE = 3'd0;
   localparam logic [2:0] ST_CRC         = 3'd1;
   localparam logic [2:0] ST_LENGTH      = 3'd2;
   localparam logic [2:0] ST_SUM_BAD     = 3'd3;
   localparam logic [2:0] ST_PAIRED      = 3'd4;
   localparam logic [2:0] ST_ID_MATCH    = 3'd5;
   localparam logic [2:0] ST_ID_MISMATCH = 3'd6;

   // Command codes written into a good frame.
   localparam logic [7:0] CMD_PAIRED = 8'h82;
   localparam logic [7:0] CMD_NORMAL = 8'h81;

   // Pair keys that request pairing.
   localparam logic [15:0] PAIR_KEY_BLANK = 16'h0000;
   localparam logic [15:0] PAIR_KEY_ALL   = 16'hFFFF;

   // Radio FIFO count limits and the expected frame length.
   localparam logic [5:0] COUNT_MIN   = 6'd3;
   localparam logic [5:0] COUNT_MAX   = 6'd15;
   localparam logic [5:0] FRAME_BYTES = 6'd9;

endpackage

`default_nettype wire

// ----- hdl/xor_keyed_frame_checker_pairing_top.sv -----
// Top level of the keyed frame checker: input register, frame logic, result register.
// A byte enters the input register; any result then enters the result register.
// Throughput: one byte per cycle unless stalled; the input register feeds one
// combinational pass into the result register, and a stalled full one holds both.
// Reset clears framing to waiting for a first byte, clears the match flag,
// and sets device_id to 0x1111 with pairing disabled.
`timescale 1ns / 1ps
`default_nettype none

module xor_keyed_frame_checker_pairing_top #(
   parameter int unsigned PAYLOAD_BYTES = 6
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_stall,
   input  wire xkfc_pkg::req_type                req_data,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   output      xkfc_pkg::rsp_type                rsp_data,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [xkfc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [xkfc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import xkfc_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    go;
   logic    out_free;
   logic    res_valid;
   rsp_type res;
   cfg_type cfg;

   // The held byte is processed once the result register can take its verdict.
   assign go        = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (go) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   xkfc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   xkfc_frame #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_frame (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .in_data   (in_data_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   xkfc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_data (res),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- hdl/xkfc_csr.sv -----
// Configuration registers: device identity and pairing mode.
`timescale 1ns / 1ps
`default_nettype none

module xkfc_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [xkfc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [xkfc_pkg::CSR_DATA_W-1:0]    csr_data,
   output      xkfc_pkg::cfg_type                  cfg
);
   import xkfc_pkg::*;

   logic [15:0] device_id_ff;
   logic        pairing_enable_ff;

   // Writes are taken in any cycle.
   assign csr_ready = 1'b1;

   // Register file; writes to unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff      <= DEVICE_ID_RESET;
         pairing_enable_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEVICE_ID:      device_id_ff      <= csr_data[15:0];
            CSR_PAIRING_ENABLE: pairing_enable_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign cfg.device_id      = device_id_ff;
   assign cfg.pairing_enable = pairing_enable_ff;

endmodule

`default_nettype wire

// ----- hdl/xkfc_frame.sv -----
// Frame tracking, decryption, checksum and pairing decision for one byte.
`timescale 1ns / 1ps
`default_nettype none

module xkfc_frame #(
   parameter int unsigned PAYLOAD_BYTES = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              go,
   input  wire xkfc_pkg::req_type in_data,
   input  wire xkfc_pkg::cfg_type cfg,
   output      logic              res_valid,
   output      xkfc_pkg::rsp_type res
);
   import xkfc_pkg::*;

   localparam int unsigned POS_W = $clog2(PAYLOAD_BYTES + 3);
   localparam logic [POS_W-1:0] POS_KEY   = POS_W'(1);
   localparam logic [POS_W-1:0] POS_FIRST = POS_W'(2);
   localparam logic [POS_W-1:0] POS_CHECK = POS_W'(PAYLOAD_BYTES + 2);
   localparam int unsigned REPORT_BYTES = 6;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             drop_ff, drop_in;
   logic [7:0]       key_ff, key_in;
   logic [7:0]       sum_ff, sum_in;
   logic             matched_ff, matched_in;
   logic [7:0]       pay_ff [REPORT_BYTES];
   logic             store_en;
   logic [7:0]       plain;
   logic [15:0]      rid;
   logic [5:0]       cnt;

   assign plain = in_data.rx_byte ^ key_ff;
   assign rid   = {pay_ff[3], pay_ff[2]};
   assign cnt   = in_data.fifo_count;

   // Next frame state and the verdict for the byte being processed.
   always_comb begin
      pos_in     = pos_ff;
      drop_in    = drop_ff;
      key_in     = key_ff;
      sum_in     = sum_ff;
      matched_in = matched_ff;
      store_en   = 1'b0;
      res_valid  = 1'b0;
      res        = '0;
      if (go) begin
         if (in_data.first_byte) begin
            // A first byte always restarts framing.
            pos_in  = '0;
            drop_in = 1'b1;
            if (cnt > COUNT_MAX || cnt < COUNT_MIN) begin
               res_valid  = 1'b1;
               res.status = ST_COUNT_RANGE;
            end else if (in_data.crc_error) begin
               res_valid  = 1'b1;
               res.status = ST_CRC;
            end else if (cnt != FRAME_BYTES) begin
               res_valid  = 1'b1;
               res.status = ST_LENGTH;
            end else begin
               sum_in  = in_data.rx_byte;
               pos_in  = POS_KEY;
               drop_in = 1'b0;
            end
         end else if (!drop_ff) begin
            if (pos_ff == POS_KEY) begin
               key_in = in_data.rx_byte;
               sum_in = sum_ff + in_data.rx_byte;
               pos_in = POS_FIRST;
            end else if (pos_ff != POS_CHECK) begin
               store_en = 1'b1;
               sum_in   = sum_ff + plain;
               pos_in   = pos_ff + POS_W'(1);
            end else begin
               // Checksum byte closes the frame.
               pos_in    = '0;
               drop_in   = 1'b1;
               res_valid = 1'b1;
               if (in_data.rx_byte != sum_ff) begin
                  res.status = ST_SUM_BAD;
               end else if (cfg.pairing_enable &&
                            (rid == PAIR_KEY_BLANK || rid == PAIR_KEY_ALL)) begin
                  res.status        = ST_PAIRED;
                  res.pkt_type      = pay_ff[0];
                  res.command       = CMD_PAIRED;
                  res.pair_key_out  = cfg.device_id;
                  res.key_value     = pay_ff[4];
                  res.reserved_byte = pay_ff[5];
                  res.received_id   = rid;
               end else if (rid != cfg.device_id) begin
                  matched_in      = 1'b0;
                  res.status      = ST_ID_MISMATCH;
                  res.command     = CMD_NORMAL;
                  res.received_id = rid;
               end else begin
                  matched_in        = 1'b1;
                  res.status        = ST_ID_MATCH;
                  res.pkt_type      = pay_ff[0];
                  res.command       = CMD_NORMAL;
                  res.pair_key_out  = rid;
                  res.key_value     = pay_ff[4];
                  res.reserved_byte = pay_ff[5];
                  res.received_id   = rid;
               end
            end
         end
      end
      res.accepted = matched_in | cfg.pairing_enable;
   end

   // Frame control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         drop_ff    <= 1'b1;
         key_ff     <= '0;
         sum_ff     <= '0;
         matched_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         drop_ff    <= drop_in;
         key_ff     <= key_in;
         sum_ff     <= sum_in;
         matched_ff <= matched_in;
      end
   end

   // Plaintext bytes that are reported; later payload bytes are only summed.
   always_ff @(posedge clock) begin
      if (store_en) begin
         for (int i = 0; i < REPORT_BYTES; i++) begin
            if (pos_ff == POS_W'(i + 2)) begin
               pay_ff[i] <= plain;
            end
         end
      end
   end

   // While a frame is open the position has moved past the length byte.
   a_open_frame_pos: assert property (@(posedge clock) disable iff (reset)
      !drop_ff |-> pos_ff != '0)
      else $error("open frame with position zero");

   // The checksum byte always returns the block to waiting.
   a_check_closes: assert property (@(posedge clock) disable iff (reset)
      go && !in_data.first_byte && !drop_ff && pos_ff == POS_CHECK
      |=> drop_ff && pos_ff == '0)
      else $error("checksum byte did not close the frame");

   // A mismatch hides the payload and clears the match flag.
   a_mismatch_clean: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.status == ST_ID_MISMATCH
      |-> res.pair_key_out == '0 && res.pkt_type == '0 && !matched_in
          && res.accepted == cfg.pairing_enable)
      else $error("mismatch verdict leaked payload or match flag");

endmodule

`default_nettype wire

// ----- hdl/xkfc_out_reg.sv -----
// Result register on the response channel.
`timescale 1ns / 1ps
`default_nettype none

module xkfc_out_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire xkfc_pkg::rsp_type load_data,
   output      logic              out_free,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      xkfc_pkg::rsp_type rsp_data
);
   import xkfc_pkg::*;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // The register can take a new result when empty or when its result leaves now.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Valid flag: set by a load, cleared by a completed transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Payload is captured only on a load.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= load_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
